FILE: src/box_blur_3x3_rgb_top_defines.svh
// Assertion macros for the checker file of the blur block.
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BB3_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bb3 check failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bb3 check failed");

`endif

FILE: src/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 12;   // 9 * 255 fits
    localparam int CNT_W     = 4;    // window size 1..9
    localparam int QUO_W     = 8;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int WCFG_W    = 12;
    localparam int HCFG_W    = 13;
    localparam int NUM_CH    = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // One pixel: index 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_rgb;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_READ,
        ST_LAST,
        ST_DSTART,
        ST_DWAIT,
        ST_EMIT
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic                          start;
        logic [CNT_W-1:0]              count;
        logic [NUM_CH-1:0][SUM_W-1:0]  sum;
    } t_div_req;

    typedef struct packed {
        logic                          done;
        logic [NUM_CH-1:0][QUO_W-1:0]  quo;
    } t_div_rsp;

    // Row slot arithmetic, slots count modulo 3
    function automatic logic [1:0] slot_next(input logic [1:0] s);
        logic [1:0] r;
        r = (s == 2'd2) ? 2'd0 : s + 2'd1;
        return r;
    endfunction

    function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] d);
        logic [2:0] t;
        t = {1'b0, s} + 3'd3 - {1'b0, d};
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/box_blur_3x3_rgb_top.sv
`default_nettype none

// 3x3 box blur of an RGB frame streamed in raster order. Each input pixel is written to a
// three-row line store; it then releases 0 to 4 blurred pixels, given in raster order with
// their row and column, tlast on the last one. The window is clipped at the frame edges and
// the average is rounded half up. Each result is a walk of its window through the single read
// port of the line store (one window pixel per cycle), then a pass through the bit-serial
// divider. The bottom right corner pixel costs most, with windows of 9, 6, 6 and 4 pixels.
// A new input is taken while the last result of the previous one still waits in the output
// register. Writing either size register restarts the frame.
// The line store needs no clearing after reset.
module box_blur_3x3_rgb_top
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input pixels
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // in_red, in_green, in_blue
    // blurred pixels
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // out_row, out_column, out_red,
                                                 // out_green, out_blue, zero pad
    output logic                 m_axis_tlast    // run_last
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = 17;
    localparam logic [AW-1:0] SLOT1_BASE = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] SLOT2_BASE = AW'(2 * MAX_WIDTH);
    localparam logic [CW-1:0] WM1_RST = CW'(((MAX_WIDTH < 2048) ? MAX_WIDTH : 2048) - 1);
    localparam logic [RW-1:0] HM1_RST = RW'(((MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096) - 1);

    function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
        logic [AW-1:0] b;
        case (s)
            2'd1:    b = SLOT1_BASE;
            2'd2:    b = SLOT2_BASE;
            default: b = '0;
        endcase
        return b;
    endfunction

    t_state r_state, n_state;

    // frame size (stored as size minus one) and position of the next input
    logic [CW-1:0] r_wm1;
    logic [RW-1:0] r_hm1;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [1:0]    r_slot;

    // current item
    logic [RW-1:0] r_ir;
    logic [CW-1:0] r_ic;
    logic [1:0]    r_islot;
    logic [1:0]    r_row_en;
    logic [1:0]    r_col_en;
    logic [1:0]    r_k;

    // current result and window walk
    logic [RW-1:0] r_orow;
    logic [CW-1:0] r_ocol;
    logic          r_olast;
    logic [RW-1:0] r_wr, r_r1;
    logic [CW-1:0] r_wc, r_c0, r_c1;
    logic [1:0]    r_wslot;
    logic [CNT_W-1:0] r_cnt;
    logic          r_rd_vld;
    logic [NUM_CH-1:0][SUM_W-1:0] r_sum;

    // output register
    logic                 r_out_vld;
    logic [OUT_ROW_W-1:0] r_out_row;
    logic [OUT_COL_W-1:0] r_out_col;
    t_rgb                 r_out_rgb;
    logic                 r_out_last;

    logic in_acc, cfg_wr, out_free;
    logic mem_rd_en, div_start, out_load;
    logic [1:0] acc_row_en, acc_col_en;
    logic [3:0] en_vec;
    logic k_en, k_last, walk_end;
    t_rgb mem_rd_data;
    logic [AW-1:0] wr_addr, rd_addr;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [RW-1:0] pr, pr0, pr1;
    logic [CW-1:0] pc, pc0, pc1;
    logic [1:0]    back;
    logic [1:0]    pslot;

    logic [XW-1:0] wval, hval, wclamp, hclamp;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign in_acc      = s_axis_tvalid & s_axis_tready;
    assign out_free    = ~r_out_vld | m_axis_tready;

    // clamp of a written size into 1..MAX
    always_comb begin
        wval   = XW'(i_cfg_data[WCFG_W-1:0]);
        hval   = XW'(i_cfg_data[HCFG_W-1:0]);
        wclamp = (wval == '0) ? XW'(1) : ((wval > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : wval);
        hclamp = (hval == '0) ? XW'(1) : ((hval > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : hval);
    end

    // which results the incoming pixel releases
    assign acc_row_en = {r_row == r_hm1, r_row != '0};
    assign acc_col_en = {r_col == r_wm1, r_col != '0};

    // result selection: bit 1 of k picks the row, bit 0 the column
    assign en_vec = {r_row_en[1] & r_col_en[1], r_row_en[1] & r_col_en[0],
                     r_row_en[0] & r_col_en[1], r_row_en[0] & r_col_en[0]};
    assign k_en   = en_vec[r_k];
    assign k_last = ~|(en_vec >> ({1'b0, r_k} + 3'd1));

    // clipped window of the selected result
    always_comb begin
        pr    = r_k[1] ? r_ir : r_ir - 1'b1;
        pc    = r_k[0] ? r_ic : r_ic - 1'b1;
        pr0   = (pr != '0) ? pr - 1'b1 : pr;
        pr1   = (pr != r_hm1) ? pr + 1'b1 : pr;
        pc0   = (pc != '0) ? pc - 1'b1 : pc;
        pc1   = (pc != r_wm1) ? pc + 1'b1 : pc;
        back  = {1'b0, ~r_k[1]} + {1'b0, pr != '0};
        pslot = slot_back(r_islot, back);
    end

    assign walk_end = (r_wc == r_c1) && (r_wr == r_r1);
    assign wr_addr  = slot_base(r_slot) + AW'(r_col);
    assign rd_addr  = slot_base(r_wslot) + AW'(r_wc);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc && (|acc_row_en) && (|acc_col_en)) n_state = ST_PICK;
            ST_PICK:   if (k_en) n_state = ST_READ;
            ST_READ:   if (walk_end) n_state = ST_LAST;
            ST_LAST:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT:  if (div_rsp.done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = r_olast ? ST_IDLE : ST_PICK;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_rd_en     = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_READ:   mem_rd_en     = 1'b1;
            ST_DSTART: div_start     = 1'b1;
            ST_EMIT:   out_load      = out_free;
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wm1     <= WM1_RST;
            r_hm1     <= HM1_RST;
            r_row     <= '0;
            r_col     <= '0;
            r_slot    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_rd_en;
            // position of the next input
            if (cfg_wr) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    r_wm1 <= CW'(wclamp - XW'(1));
                end
                if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                    r_hm1 <= RW'(hclamp - XW'(1));
                end
                if (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_slot <= '0;
                end
            end else if (in_acc) begin
                if (r_col == r_wm1) begin
                    r_col <= '0;
                    if (r_row == r_hm1) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + 1'b1;
                        r_slot <= slot_next(r_slot);
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            // output register
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item, walk and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ir     <= r_row;
            r_ic     <= r_col;
            r_islot  <= r_slot;
            r_row_en <= acc_row_en;
            r_col_en <= acc_col_en;
            r_k      <= '0;
        end
        if (r_state == ST_PICK) begin
            if (k_en) begin
                r_orow  <= pr;
                r_ocol  <= pc;
                r_olast <= k_last;
                r_wr    <= pr0;
                r_r1    <= pr1;
                r_wc    <= pc0;
                r_c0    <= pc0;
                r_c1    <= pc1;
                r_wslot <= pslot;
                r_cnt   <= '0;
                r_sum   <= '0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
        // walk the window, one pixel a cycle
        if (mem_rd_en) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_wc == r_c1) begin
                r_wc    <= r_c0;
                r_wr    <= r_wr + 1'b1;
                r_wslot <= slot_next(r_wslot);
            end else begin
                r_wc <= r_wc + 1'b1;
            end
        end
        // accumulate read data
        if (r_rd_vld) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_sum[ch] <= r_sum[ch] + SUM_W'(mem_rd_data[ch]);
            end
        end
        if (out_load) begin
            r_out_row  <= OUT_ROW_W'(r_orow);
            r_out_col  <= OUT_COL_W'(r_ocol);
            r_out_rgb  <= div_rsp.quo;
            r_out_last <= r_olast;
            if (!r_olast) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    bb3_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (wr_addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign div_req.start = div_start;
    assign div_req.count = r_cnt;
    assign div_req.sum   = r_sum;

    bb3_round_div u_round_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_rgb, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: src/bb3_line_mem.sv
`default_nettype none

// Line store: one write port, one registered read port.
module bb3_line_mem
    import bb3_pkg::*;
#(
    parameter int DEPTH = 6144,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_rgb          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_rgb          o_rd_data
);

    t_rgb r_mem [DEPTH];
    t_rgb r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/bb3_round_div.sv
`default_nettype none

// Rounded average per channel: floor((2*sum+count)/(2*count)).
// Restoring division, one quotient bit per cycle, 3 channels side by side.
module bb3_round_div
    import bb3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int DIVD_W = SUM_W + 1;
    localparam int STEP_W = $clog2(QUO_W);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [CNT_W:0]                r_dvs;
    logic [NUM_CH-1:0][DIVD_W-1:0] r_rem;
    logic [NUM_CH-1:0][QUO_W-1:0]  r_quo;

    logic [DIVD_W-1:0]             shifted;
    logic [NUM_CH-1:0][DIVD_W-1:0] n_rem;
    logic [NUM_CH-1:0]             fits;

    // Trial subtraction of the shifted divisor
    always_comb begin
        shifted = DIVD_W'(r_dvs) << r_step;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            fits[ch]  = (r_rem[ch] >= shifted);
            n_rem[ch] = fits[ch] ? r_rem[ch] - shifted : r_rem[ch];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= {i_req.count, 1'b0};
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_rem[ch] <= {i_req.sum[ch], 1'b0} + DIVD_W'(i_req.count);
                r_quo[ch] <= '0;
            end
        end else if (r_busy) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_rem[ch]         <= n_rem[ch];
                r_quo[ch][r_step] <= fits[ch];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

FILE: src/bb3_checker.sv
`default_nettype none

`include "box_blur_3x3_rgb_top_defines.svh"

// Port-level checks on the blur block.
module bb3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result stays offered
    `BB3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a stalled result does not change
    `BB3_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // no new pixel while results of the current one are still owed
    `BB3_ASSERT_SAME(a_no_input_mid_run, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // a result needs the window walk: never offered right after an input
    `BB3_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (.*);

`default_nettype wire

FILE: tb/tb_box_blur_3x3_rgb_top.sv
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb_top;
    import bb3_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int MAX_H        = 4096;
    localparam int HOLD_LONG    = 400;   // receiver hold-off for the fill-up test
    localparam int SETTLE       = 100;   // idle margin after the last predicted result
    localparam int STALL_LIMIT  = 5000;  // cycles with no item moving anywhere
    localparam int PIXEL_BUDGET = 480;

    // indexes past the two size registers, the block ignores them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic                 last;
    } t_blurred_px;

    // Tracks the frame position and the last three rows, and predicts the
    // blurred pixels each accepted input releases.
    class blur_scoreboard;
        logic [PIX_W-1:0] rows_kept [3][MAX_W][NUM_CH];
        int unsigned      width_reg;
        int unsigned      height_reg;
        int unsigned      row_pos;
        int unsigned      col_pos;
        t_blurred_px      blurred_q[$];
        int unsigned      errors;
        int unsigned      pixels_seen;
        int unsigned      results_seen;

        function new();
            width_reg    = MAX_W;
            height_reg   = MAX_H;
            row_pos      = 0;
            col_pos      = 0;
            errors       = 0;
            pixels_seen  = 0;
            results_seen = 0;
        endfunction

        // sizes in use, zero reads as one, oversize clips to the maximum
        function int unsigned frame_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_H) return MAX_H;
            return height_reg;
        endfunction

        function int unsigned outstanding();
            return blurred_q.size();
        endfunction

        // size writes restart the frame, other indexes do nothing
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH: begin
                    width_reg = int'(data[WCFG_W-1:0]);
                    row_pos   = 0;
                    col_pos   = 0;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = int'(data[HCFG_W-1:0]);
                    row_pos    = 0;
                    col_pos    = 0;
                end
                default: ;
            endcase
        endfunction

        // clipped 3x3 average, rounded half up
        function t_blurred_px blur_at(int unsigned r, int unsigned c,
                                      int unsigned w, int unsigned h);
            int unsigned r0, r1, c0, c1, cnt;
            int unsigned sum [NUM_CH];
            logic [PIX_W-1:0] avg [NUM_CH];
            t_blurred_px px;
            r0  = (r > 0) ? r - 1 : 0;
            r1  = (r + 1 < h) ? r + 1 : h - 1;
            c0  = (c > 0) ? c - 1 : 0;
            c1  = (c + 1 < w) ? c + 1 : w - 1;
            cnt = 0;
            sum = '{0, 0, 0};
            for (int unsigned i = r0; i <= r1; i++) begin
                for (int unsigned j = c0; j <= c1; j++) begin
                    cnt++;
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        sum[ch] += int'(rows_kept[i % 3][j][ch]);
                    end
                end
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                avg[ch] = PIX_W'((2 * sum[ch] + cnt) / (2 * cnt));
            end
            px.row   = OUT_ROW_W'(r);
            px.col   = OUT_COL_W'(c);
            px.red   = avg[0];
            px.green = avg[1];
            px.blue  = avg[2];
            px.last  = 1'b0;
            return px;
        endfunction

        // store the pixel, queue what it releases, advance the position
        function void take_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                                 logic [PIX_W-1:0] blue);
            int unsigned w, h, ir, ic, nr, nc;
            int unsigned rows [2];
            int unsigned cols [2];
            t_blurred_px px;
            w  = frame_width();
            h  = frame_height();
            ir = (row_pos >= h) ? h - 1 : row_pos;
            ic = (col_pos >= w) ? w - 1 : col_pos;
            rows_kept[ir % 3][ic][0] = red;
            rows_kept[ir % 3][ic][1] = green;
            rows_kept[ir % 3][ic][2] = blue;
            nr = 0;
            nc = 0;
            if (ir >= 1) begin
                rows[nr] = ir - 1;
                nr++;
            end
            if (ir == h - 1) begin
                rows[nr] = ir;
                nr++;
            end
            if (ic >= 1) begin
                cols[nc] = ic - 1;
                nc++;
            end
            if (ic == w - 1) begin
                cols[nc] = ic;
                nc++;
            end
            for (int unsigned a = 0; a < nr; a++) begin
                for (int unsigned b = 0; b < nc; b++) begin
                    px      = blur_at(rows[a], cols[b], w, h);
                    px.last = (a == nr - 1) && (b == nc - 1);
                    blurred_q.push_back(px);
                end
            end
            ic++;
            if (ic >= w) begin
                ic = 0;
                ir++;
                if (ir >= h) ir = 0;
            end
            row_pos = ir;
            col_pos = ic;
            pixels_seen++;
        endfunction

        function void check_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // compare one output item against the oldest prediction
        function void check_result(logic [47:0] data, logic last);
            t_blurred_px want;
            results_seen++;
            if (blurred_q.size() == 0) begin
                $error("blurred pixel row %0d column %0d arrived with none expected",
                       data[11:0], data[22:12]);
                errors++;
                return;
            end
            want = blurred_q.pop_front();
            check_field("out_row",    want.row,   data[11:0]);
            check_field("out_column", want.col,   data[22:12]);
            check_field("out_red",    want.red,   data[30:23]);
            check_field("out_green",  want.green, data[38:31]);
            check_field("out_blue",   want.blue,  data[46:39]);
            check_field("pad",        0,          data[47]);
            check_field("run_last",   want.last,  last);
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // in_red, in_green, in_blue
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;         // out_row, out_column, out_red,
                                                // out_green, out_blue, zero pad
    logic                 m_axis_tlast;         // run_last

    blur_scoreboard sb = new();

    bit          src_eager    = 1'b0;  // sender offers back to back
    bit          sink_eager   = 1'b0;  // receiver never stalls
    bit          pressure_req = 1'b0;
    int unsigned sink_hold    = 0;
    int unsigned quiet_cycles = 0;

    box_blur_3x3_rgb_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // full scale, zero or random, for the directed frames
    function automatic logic [PIX_W-1:0] pick_level(int unsigned k);
        case (k % 4)
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: check accepted items, then choose next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
        if (pressure_req) begin
            pressure_req = 1'b0;
            sink_hold    = HOLD_LONG;
        end
        if (sink_hold == 0 && !sink_eager) begin
            sink_hold = idle_len();
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no item moved for %0d cycles, %0d results outstanding",
                   quiet_cycles, sb.outstanding());
            $display("tb_box_blur_3x3_rgb_top failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue);
        int unsigned gap;
        gap = src_eager ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_pixel(red, green, blue);
    endtask

    task automatic send_random(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)));
        end
    endtask

    // valid stays up; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(h));
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every predicted result, then for inputs that release nothing
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick, new_w, new_h, area, n_items, settings;
        settings = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full 3x3 frame plus a wrap into the next one
        set_frame(3, 3);
        for (int unsigned k = 0; k < 10; k++) begin
            send_pixel(pick_level(k), pick_level(k + 1), pick_level(k + 2));
        end
        settle();
        // zero sizes act as a single pixel
        set_frame(0, 0);
        send_random(2);
        settle();
        // a write to an unused index must not restart the frame
        set_frame(2, 2);
        send_random(3);
        settle();
        write_reg(REG_SPARE_2, CFG_DAT_W'($urandom_range(0, 8191)));
        write_reg(REG_SPARE_3, CFG_DAT_W'($urandom_range(0, 8191)));
        i_cfg_valid <= 1'b0;
        send_random(3);
        settle();
        // oversize width clips to the maximum, single row
        set_frame(4095, 1);
        for (int unsigned k = 0; k < 4; k++) begin
            send_pixel(pick_level(k + 1), pick_level(k), pick_level(k + 3));
        end
        settle();
        // single column, oversize height
        set_frame(1, 8191);
        send_random(3);
        settle();
        settings = 5;

        // receiver holds off while the sender keeps offering
        src_eager    = 1'b1;
        sink_eager   = 1'b0;
        set_frame(5, 4);
        pressure_req = 1'b1;
        send_random(60);
        settle();
        settings++;

        // random frame sizes, mostly small
        while (sb.pixels_seen < PIXEL_BUDGET) begin
            src_eager  = ($urandom_range(0, 3) == 0);
            sink_eager = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)      new_w = $urandom_range(1, 12);
            else if (pick < 82) new_w = $urandom_range(13, 64);
            else if (pick < 87) new_w = 0;
            else if (pick < 91) new_w = MAX_W;
            else if (pick < 95) new_w = $urandom_range(MAX_W + 1, 4095);
            else                new_w = $urandom_range(65, MAX_W - 1);
            new_w = new_w | ($urandom_range(0, 1) << WCFG_W);   // bit above the field
            pick = $urandom_range(0, 99);
            if (pick < 70)      new_h = $urandom_range(1, 8);
            else if (pick < 82) new_h = $urandom_range(9, 40);
            else if (pick < 87) new_h = 0;
            else if (pick < 92) new_h = MAX_H;
            else                new_h = $urandom_range(MAX_H + 1, 8191);

            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(new_w));
            end else if (pick == 1) begin
                write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(new_h));
            end else begin
                if (pick == 2) begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                              CFG_DAT_W'($urandom_range(0, 8191)));
                end
                write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(new_w));
                write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(new_h));
            end
            i_cfg_valid <= 1'b0;
            settings++;

            area = sb.frame_width() * sb.frame_height();
            if (area <= 100) n_items = $urandom_range(4, (2 * area + 4 > 80) ? 80 : 2 * area + 4);
            else             n_items = $urandom_range(8, 40);
            send_random(n_items);
            settle();
        end

        if (sb.outstanding() != 0) begin
            $error("%0d blurred pixels never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("Run covered %0d pixels and %0d blurred results over %0d frame settings,",
                 sb.pixels_seen, sb.results_seen, settings);
        $display("clipped and zero sizes, ignored indexes and a %0d-cycle output hold-off.",
                 HOLD_LONG);
        if (sb.errors == 0) begin
            $display("tb_box_blur_3x3_rgb_top passed");
        end else begin
            $display("tb_box_blur_3x3_rgb_top failed");
        end
        $finish;
    end

endmodule
